// File: rtl/core/icfu_pkg.sv
// Shared types, constants and the xorshift step for the cluster flip block.
// No dependencies.
`timescale 1ns / 1ps
package icfu_pkg;
    localparam int unsigned ACTION_FLIP = 0;
    localparam int unsigned ACTION_READ = 1;
    localparam logic [31:0] THRESH_RESET = 32'd2515933582;
    localparam logic [63:0] SEED_RESET = 64'd1;
    localparam logic CFG_THRESH = 1'b0;
    localparam logic CFG_SEED = 1'b1;

    typedef struct packed {
        logic       action;
        logic [5:0] row;
        logic [5:0] col;
    } req_t;

    function automatic logic [63:0] xorshift(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 7);
        return b ^ (b << 17);
    endfunction
endpackage

// File: rtl/core/ising_cluster_flip_update_top.sv
// Wolff cluster update over a SIDE x SIDE periodic spin lattice.
// Depends on icfu_pkg and icfu_ram.
//
// channel  dir  handshake                 payload
// s_axis   in   s_axis_tvalid/tready      tdata {col,row,action}
// m_axis   out  m_axis_tvalid/tready      tdata {spin_row,cluster_size}
// cfg      in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
// Lattice rows sit in a RAM of SIDE words; the site stack in a RAM.
// A read waits out the registered row read. A flip reads and flips the seed,
// pushes it, pops each site (pop, pop wait), and per neighbour does row read,
// read wait, test and write back. Reset clears all SIDE rows, taking no item.
// The result waits in an output register; the next item is taken meanwhile
// and its result holds until that register is free.
`timescale 1ns / 1ps
module ising_cluster_flip_update_top #(
    parameter int SIDE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // action, row[5:0], col[5:0], pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // cluster_size[12:0], spin_row[63:0], pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int RW = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int SW = $clog2(SIDE * SIDE);
    localparam int CW = SW + 1;
    localparam int EW = 2 * RW;

    typedef enum logic [3:0] {
        CLEAR, IDLE, RD_WAIT, RD_OUT, F_RD, F_WAIT, F_WR,
        POP, POP_WAIT, NB_RD, NB_WAIT, NB_TEST, DONE
    } state_t;

    state_t      state_reg;
    logic [31:0] thresh_reg;
    logic [63:0] rand_reg;
    logic [RW-1:0] row_reg, col_reg, r_reg, c_reg, nr_reg, nc_reg;
    logic [1:0]  nb_reg;
    logic        old_reg;
    logic [CW-1:0] sp_reg, flips_reg;
    logic        ov_reg;
    logic [76:0] out_reg;
    logic        out_load;

    logic          lat_we;
    logic [RW-1:0] lat_wa, lat_ra;
    logic [SIDE-1:0] lat_wd, lat_rd;
    logic          stk_we;
    logic [SW-1:0] stk_wa, stk_ra;
    logic [EW-1:0] stk_rd, stk_wd;

    icfu_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_lat (
        .clk(clk), .we(lat_we), .waddr(lat_wa), .wdata(lat_wd),
        .raddr(lat_ra), .rdata(lat_rd));
    icfu_ram #(.WIDTH(EW), .DEPTH(SIDE * SIDE)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
        .raddr(stk_ra), .rdata(stk_rd));

    icfu_pkg::req_t req;
    logic [63:0] draw;
    logic        join_ok;
    logic [63:0] row_pad;
    assign req.action = s_axis_tdata[0];
    assign req.row    = s_axis_tdata[6:1];
    assign req.col    = s_axis_tdata[12:7];
    assign draw    = icfu_pkg::xorshift(rand_reg);
    assign join_ok = draw[63:32] < thresh_reg;
    assign row_pad = 64'(lat_rd);

    // modulo SIDE by compare and subtract of shifted multiples
    function automatic logic [RW-1:0] wrap(input logic [5:0] v);
        logic [12:0] t;
        t = {7'b0, v};
        for (int k = 5; k >= 0; k--)
        begin
            if (t >= (13'(SIDE) << k))
            begin
                t = t - (13'(SIDE) << k);
            end
        end
        return t[RW-1:0];
    endfunction

    function automatic logic [RW-1:0] inc(input logic [RW-1:0] v);
        return (32'(v) == SIDE - 1) ? '0 : RW'(32'(v) + 1);
    endfunction

    function automatic logic [RW-1:0] dec(input logic [RW-1:0] v);
        return (v == '0) ? RW'(SIDE - 1) : RW'(32'(v) - 1);
    endfunction

    assign s_axis_tready = (state_reg == IDLE);
    assign cfg_ready     = (state_reg == IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {3'b0, out_reg};
    assign out_load      = ((state_reg == RD_OUT) || (state_reg == DONE))
                           && (!ov_reg || m_axis_tready);

    logic [EW-1:0] push_site;
    assign push_site = {nr_reg, nc_reg};

    always_comb
    begin
        lat_we = 1'b0;
        lat_wa = r_reg;
        lat_wd = lat_rd;
        lat_ra = row_reg;
        stk_we = 1'b0;
        stk_wa = sp_reg[SW-1:0];
        stk_wd = push_site;
        stk_ra = SW'(sp_reg - 1'b1);
        unique case (state_reg)
            CLEAR:
            begin
                lat_we = 1'b1;
                lat_wa = r_reg;
                lat_wd = '0;
            end
            IDLE:
            begin
                lat_ra = wrap(req.row);
            end
            F_WR:
            begin
                lat_we = 1'b1;
                lat_wa = row_reg;
                lat_wd = lat_rd ^ (SIDE'(1) << col_reg);
                stk_we = 1'b1;
                stk_wa = '0;
                stk_wd = {row_reg, col_reg};
            end
            NB_RD:
            begin
                lat_ra = nr_reg;
            end
            NB_WAIT:
            begin
                lat_ra = nr_reg;
            end
            NB_TEST:
            begin
                if (lat_rd[nc_reg] == old_reg && join_ok)
                begin
                    lat_we = 1'b1;
                    lat_wa = nr_reg;
                    lat_wd = lat_rd ^ (SIDE'(1) << nc_reg);
                    stk_we = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= CLEAR;
            thresh_reg <= icfu_pkg::THRESH_RESET;
            rand_reg   <= icfu_pkg::SEED_RESET;
            r_reg      <= '0;
            c_reg      <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            nr_reg     <= '0;
            nc_reg     <= '0;
            old_reg    <= 1'b0;
            out_reg    <= '0;
            ov_reg     <= 1'b0;
            sp_reg     <= '0;
            flips_reg  <= '0;
            nb_reg     <= '0;
        end
        else
        begin
            if (ov_reg && m_axis_tready && !out_load)
            begin
                ov_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == icfu_pkg::CFG_THRESH)
                begin
                    thresh_reg <= cfg_data[31:0];
                end
                else
                begin
                    rand_reg <= cfg_data;
                end
            end
            unique case (state_reg)
                CLEAR:
                begin
                    r_reg <= inc(r_reg);
                    if (32'(r_reg) == SIDE - 1)
                    begin
                        state_reg <= IDLE;
                    end
                end
                IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        row_reg <= wrap(req.row);
                        col_reg <= wrap(req.col);
                        state_reg <= (32'(req.action) == icfu_pkg::ACTION_READ)
                                     ? RD_WAIT : F_WAIT;
                    end
                end
                RD_WAIT:
                begin
                    state_reg <= RD_OUT;
                end
                RD_OUT:
                begin
                    if (out_load)
                    begin
                        out_reg   <= {row_pad, 13'd0};
                        ov_reg    <= 1'b1;
                        state_reg <= IDLE;
                    end
                end
                F_WAIT:
                begin
                    state_reg <= F_RD;
                end
                F_RD:
                begin
                    old_reg   <= lat_rd[col_reg];
                    state_reg <= F_WR;
                end
                F_WR:
                begin
                    sp_reg    <= CW'(1);
                    flips_reg <= CW'(1);
                    state_reg <= POP;
                end
                POP:
                begin
                    if (sp_reg == '0)
                    begin
                        state_reg <= DONE;
                    end
                    else
                    begin
                        state_reg <= POP_WAIT;
                    end
                end
                POP_WAIT:
                begin
                    r_reg     <= stk_rd[EW-1:RW];
                    c_reg     <= stk_rd[RW-1:0];
                    sp_reg    <= sp_reg - 1'b1;
                    nb_reg    <= '0;
                    state_reg <= NB_RD;
                    nr_reg    <= inc(stk_rd[EW-1:RW]);
                    nc_reg    <= stk_rd[RW-1:0];
                end
                NB_RD:
                begin
                    state_reg <= NB_WAIT;
                end
                NB_WAIT:
                begin
                    state_reg <= NB_TEST;
                end
                NB_TEST:
                begin
                    if (lat_rd[nc_reg] == old_reg)
                    begin
                        rand_reg <= draw;
                        if (join_ok)
                        begin
                            sp_reg    <= sp_reg + 1'b1;
                            flips_reg <= flips_reg + 1'b1;
                        end
                    end
                    nb_reg <= nb_reg + 1'b1;
                    unique case (nb_reg)
                        2'd0:
                        begin
                            nr_reg <= dec(r_reg);
                            nc_reg <= c_reg;
                        end
                        2'd1:
                        begin
                            nr_reg <= r_reg;
                            nc_reg <= inc(c_reg);
                        end
                        2'd2:
                        begin
                            nr_reg <= r_reg;
                            nc_reg <= dec(c_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                    state_reg <= (nb_reg == 2'd3) ? POP : NB_RD;
                end
                DONE:
                begin
                    if (out_load)
                    begin
                        out_reg   <= {64'd0, 13'(flips_reg)};
                        ov_reg    <= 1'b1;
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !m_axis_tready |=> ov_reg)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= SIDE * SIDE)
        else $error("stack overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DONE |-> 32'(flips_reg) <= SIDE * SIDE && flips_reg != '0)
        else $error("bad cluster size");
endmodule

// File: rtl/core/icfu_ram.sv
// Generic simple dual-port synchronous RAM (one write, one read port), registered read.
// No dependencies.
`timescale 1ns / 1ps
module icfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: tb/ising_cluster_flip_update_top_tb.sv
// Testbench for ising_cluster_flip_update_top: a stimulus table, then random items,
// each result checked against a cluster-growth predictor in this file or a table value.
// Depends on icfu_pkg and the RTL of the block.
`timescale 1ns / 1ps
module ising_cluster_flip_update_top_tb;

    localparam int LIMIT = 50000000;

    typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_e;
    typedef struct {
        row_kind_e   kind;
        logic        idx;
        logic [63:0] val;
        logic        action;
        logic [5:0]  row;
        logic [5:0]  col;
        bit          known;
        logic [12:0] size;
        logic [63:0] mask;
    } stim_row_t;
    typedef struct packed {
        logic [12:0] size;
        logic [63:0] mask;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [63:0] cfg_data;

    logic [63:0] lattice [64];
    logic [11:0] site_stk [4096];
    logic [31:0] thresh;
    logic [63:0] rng;
    result_t     results_due [$];
    stim_row_t   dir_tbl [$];
    int          errors;
    int          cycles;
    bit          hold_req;
    bit          rx_quiet;

    ising_cluster_flip_update_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] next_draw();
        logic [63:0] x;
        x = rng;
        x = x ^ (x << 13);
        x = x ^ (x >> 7);
        x = x ^ (x << 17);
        rng = x;
        return x;
    endfunction

    task automatic try_join(input logic [5:0] r, input logic [5:0] c, input logic old,
                            inout int depth, inout logic [12:0] flipped);
        logic [63:0] d;
        if (lattice[r][c] == old)
        begin
            d = next_draw();
            if (d[63:32] < thresh)
            begin
                lattice[r][c] = ~lattice[r][c];
                site_stk[depth] = {r, c};
                depth++;
                flipped++;
            end
        end
    endtask

    // grows one cluster from the seed, or reads one row, and returns what the block should report
    task automatic predict_update(input logic action, input logic [5:0] r0,
                                  input logic [5:0] c0, output result_t res);
        logic        old;
        logic [5:0]  r;
        logic [5:0]  c;
        logic [12:0] flipped;
        int          depth;
        if (action == 1'(icfu_pkg::ACTION_READ))
        begin
            res.size = '0;
            res.mask = lattice[r0];
        end
        else
        begin
            old = lattice[r0][c0];
            lattice[r0][c0] = ~old;
            site_stk[0] = {r0, c0};
            depth = 1;
            flipped = 13'd1;
            while (depth > 0)
            begin
                depth--;
                {r, c} = site_stk[depth];
                try_join(r + 6'd1, c, old, depth, flipped);
                try_join(r - 6'd1, c, old, depth, flipped);
                try_join(r, c + 6'd1, old, depth, flipped);
                try_join(r, c - 6'd1, old, depth, flipped);
            end
            res.size = flipped;
            res.mask = '0;
        end
    endtask

    task automatic send_item(input logic action, input logic [5:0] r, input logic [5:0] c,
                             input int gap, input bit known, input result_t typed);
        result_t res;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, c, r, action};
        do @(posedge clk); while (!s_axis_tready);
        predict_update(action, r, c, res);
        results_due.push_back(known ? typed : res);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (results_due.size() == 0);
        repeat (20) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == icfu_pkg::CFG_THRESH)
            thresh = val[31:0];
        else
            rng = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 60)
            return 0;
        if (n < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // receiver: random stalls, forced long hold-off, quiet stretches
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(negedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else if (!rx_quiet && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                      : $urandom_range(0, 3);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected item, size %0d mask %h", $time,
                         m_axis_tdata[12:0], m_axis_tdata[76:13]);
                errors++;
            end
            else
            begin
                exp_r = results_due.pop_front();
                if (m_axis_tdata[12:0] !== exp_r.size)
                begin
                    $display("%0t: cluster_size expected %0d actual %0d", $time,
                             exp_r.size, m_axis_tdata[12:0]);
                    errors++;
                end
                if (m_axis_tdata[76:13] !== exp_r.mask)
                begin
                    $display("%0t: spin_row expected %h actual %h", $time,
                             exp_r.mask, m_axis_tdata[76:13]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        result_t typed;
        logic    act;
        errors        = 0;
        cycles        = 0;
        hold_req      = 1'b0;
        rx_quiet      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = icfu_pkg::CFG_THRESH;
        cfg_data      = '0;
        for (int i = 0; i < 64; i++)
            lattice[i] = '0;
        thresh = icfu_pkg::THRESH_RESET;
        rng    = icfu_pkg::SEED_RESET;

        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b1, 6'd0, 6'd0, 1, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b1, 6'd63, 6'd63, 1, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b0, 6'd0, 6'd0, 0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b0, 6'd63, 6'd63, 0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b1, 6'd0, 6'd17, 0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b1, 6'd63, 6'd0, 0, 0, 0});
        dir_tbl.push_back('{ROW_CFG, icfu_pkg::CFG_THRESH, 64'd0, 1'b0, 6'd0, 6'd0,
                            0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b0, 6'd5, 6'd7,
                            1, 13'd1, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b1, 6'd5, 6'd0, 0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b0, 6'd63, 6'd0,
                            1, 13'd1, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b0, 6'd42, 6'd21,
                            1, 13'd1, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b0, 6'd21, 6'd42,
                            1, 13'd1, 0});
        // zero seed with full threshold: every like neighbour joins
        dir_tbl.push_back('{ROW_CFG, icfu_pkg::CFG_SEED, 64'd0, 1'b0, 6'd0, 6'd0,
                            0, 0, 0});
        dir_tbl.push_back('{ROW_CFG, icfu_pkg::CFG_THRESH, 64'hFFFF_FFFF, 1'b0, 6'd0, 6'd0,
                            0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b0, 6'd10, 6'd10, 0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b1, 6'd10, 6'd0, 0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b0, 6'd5, 6'd7, 0, 0, 0});
        dir_tbl.push_back('{ROW_CFG, icfu_pkg::CFG_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
                            6'd0, 6'd0, 0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b0, 6'd1, 6'd62, 0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b1, 6'd1, 6'd0, 0, 0, 0});
        dir_tbl.push_back('{ROW_CFG, icfu_pkg::CFG_THRESH, 64'd1, 1'b0, 6'd0, 6'd0,
                            0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b0, 6'd20, 6'd40, 0, 0, 0});
        dir_tbl.push_back('{ROW_ITEM, icfu_pkg::CFG_THRESH, 0, 1'b1, 6'd20, 6'd0, 0, 0, 0});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tbl[i])
        begin
            if (dir_tbl[i].kind == ROW_CFG)
                write_reg(dir_tbl[i].idx, dir_tbl[i].val);
            else
            begin
                typed.size = dir_tbl[i].size;
                typed.mask = dir_tbl[i].mask;
                send_item(dir_tbl[i].action, dir_tbl[i].row, dir_tbl[i].col, pick_gap(),
                          dir_tbl[i].known, typed);
            end
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(icfu_pkg::CFG_THRESH, (ph == 4) ? 64'h8000_0000
                                            : 64'($urandom_range(0, 32'h6000_0000)));
            write_reg(icfu_pkg::CFG_SEED, {$urandom, $urandom} | 64'd1);
            rx_quiet = (ph == 2);
            if (ph == 1)
                hold_req = 1'b1;
            for (int k = 0; k < 54; k++)
            begin
                act = ($urandom_range(0, 9) < 4) ? 1'(icfu_pkg::ACTION_READ)
                                                 : 1'(icfu_pkg::ACTION_FLIP);
                send_item(act, 6'($urandom), 6'($urandom),
                          (ph == 2) ? 0 : pick_gap(), 1'b0, typed);
            end
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (results_due.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && results_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
